>>> rtl/gimgalu_pkg.sv
// Shared constants, op codes and mod-p helper functions for the Gaussian integer ALU.
package gimgalu_pkg;

    // Field modulus p = 2^64 - 2^32 + 1 and 2^64 mod p
    localparam logic [63:0] GOLD_P   = 64'hFFFF_FFFF_0000_0001;
    localparam logic [63:0] GOLD_EPS = 64'h0000_0000_FFFF_FFFF;

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_MUL  = 2'd2,
        OP_CONJ = 2'd3
    } op_t;

    // One conditional subtract of p
    function automatic logic [63:0] canon(input logic [63:0] x);
        logic [63:0] r;
        r = (x >= GOLD_P) ? (x - GOLD_P) : x;
        return r;
    endfunction

    // a + b mod p for canonical a, b; the sum stays below 2p
    function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [64:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, GOLD_P};
        return (s >= {1'b0, GOLD_P}) ? d[63:0] : s[63:0];
    endfunction

    // a - b mod p for canonical a, b; wraps back by adding p on borrow
    function automatic logic [63:0] sub_mod(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        return (a < b) ? (d + GOLD_P) : d;
    endfunction

endpackage

>>> rtl/gimgalu_modmul.sv
// Four-stage pipelined 64x64 multiply with reduction mod p = 2^64 - 2^32 + 1.
module gimgalu_modmul
    import gimgalu_pkg::*;
(
    input  logic        aclk,
    input  logic        en,      // pipeline advance
    input  logic [63:0] a,       // canonical operand
    input  logic [63:0] b,       // canonical operand
    output logic [63:0] prod     // a*b mod p, canonical, from the prod_reg output register
);

    // Stage A: 32x32 partial products
    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= {32'b0, a[31:0]}  * {32'b0, b[31:0]};
            lh_reg <= {32'b0, a[31:0]}  * {32'b0, b[63:32]};
            hl_reg <= {32'b0, a[63:32]} * {32'b0, b[31:0]};
            hh_reg <= {32'b0, a[63:32]} * {32'b0, b[63:32]};
        end
    end

    // Stage B: assemble the 128-bit product
    logic [33:0]  mid;
    logic [63:0]  lo_next, hi_next;
    logic [63:0]  lo_reg, hi_reg;

    always_comb begin
        mid     = {2'b0, ll_reg[63:32]} + {2'b0, lh_reg[31:0]} + {2'b0, hl_reg[31:0]};
        lo_next = {mid[31:0], ll_reg[31:0]};
        hi_next = hh_reg + {32'b0, lh_reg[63:32]} + {32'b0, hl_reg[63:32]}
                  + {62'b0, mid[33:32]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Stage C: fold high words, 2^96 = -1 and 2^64 = 2^32 - 1 mod p
    logic [64:0] t0_diff;
    logic [63:0] t0_next, t1_next;
    logic [63:0] t0_reg, t1_reg;

    always_comb begin
        t0_diff = {1'b0, lo_reg} - {33'b0, hi_reg[63:32]};
        t0_next = t0_diff[64] ? (t0_diff[63:0] - GOLD_EPS) : t0_diff[63:0];
        t1_next = {hi_reg[31:0], 32'b0} - {32'b0, hi_reg[31:0]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
        end
    end

    // Stage D: final add; the sum stays below 2p so one subtract suffices
    logic [64:0] sum;
    logic [64:0] sum_red;
    logic [63:0] prod_next;
    logic [63:0] prod_reg;

    always_comb begin
        sum       = {1'b0, t0_reg} + {1'b0, t1_reg};
        sum_red   = sum - {1'b0, GOLD_P};
        prod_next = (sum >= {1'b0, GOLD_P}) ? sum_red[63:0] : sum[63:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/gaussian_int_mod_goldilocks_alu.sv
// Gaussian integer ALU over GF(2^64 - 2^32 + 1): add, subtract, multiply, conjugate.
// Pipeline: six register stages from input transfer to result valid (operand
//   canon, four multiplier stages, final combine into the output register).
// Throughput: one item per cycle; the whole pipeline stalls while a result waits with
//   m_axis_tready low.
// Reset: aresetn (synchronous, active low) clears all stage valid bits; data regs are not reset.
module gaussian_int_mod_goldilocks_alu
    import gimgalu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input channel
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,   // a_re[63:0], a_im[127:64], b_re[191:128], b_im[255:192]
    input  logic [1:0]   s_axis_tuser,   // op[1:0]
    // result channel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // z_re[63:0], z_im[127:64]
);

    localparam int DLY = 3;  // stages 3..5 carrying the non-multiply result

    logic en;

    // Whole pipeline moves when the output slot is free or being taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: operand canonicalization
    logic        v1_reg;
    op_t         op1_reg;
    logic [63:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg <= op_t'(s_axis_tuser);
            ar1_reg <= canon(s_axis_tdata[63:0]);
            ai1_reg <= canon(s_axis_tdata[127:64]);
            br1_reg <= canon(s_axis_tdata[191:128]);
            bi1_reg <= canon(s_axis_tdata[255:192]);
        end
    end

    // Stages 2..5: four products mod p
    logic [63:0] m_rr, m_ii, m_ri, m_ir;

    gimgalu_modmul u_mul_rr (.aclk(aclk), .en(en), .a(ar1_reg), .b(br1_reg), .prod(m_rr));
    gimgalu_modmul u_mul_ii (.aclk(aclk), .en(en), .a(ai1_reg), .b(bi1_reg), .prod(m_ii));
    gimgalu_modmul u_mul_ri (.aclk(aclk), .en(en), .a(ar1_reg), .b(bi1_reg), .prod(m_ri));
    gimgalu_modmul u_mul_ir (.aclk(aclk), .en(en), .a(ai1_reg), .b(br1_reg), .prod(m_ir));

    // Stage 2: add / subtract / conjugate results
    logic [63:0] zr2_next, zi2_next;
    logic        v2_reg;
    op_t         op2_reg;
    logic [63:0] zr2_reg, zi2_reg;

    always_comb begin
        case (op1_reg)
            OP_ADD: begin
                zr2_next = add_mod(ar1_reg, br1_reg);
                zi2_next = add_mod(ai1_reg, bi1_reg);
            end
            OP_SUB: begin
                zr2_next = sub_mod(ar1_reg, br1_reg);
                zi2_next = sub_mod(ai1_reg, bi1_reg);
            end
            default: begin
                // conjugate; multiply ignores this path
                zr2_next = ar1_reg;
                zi2_next = sub_mod(64'd0, ai1_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op2_reg <= op1_reg;
            zr2_reg <= zr2_next;
            zi2_reg <= zi2_next;
        end
    end

    // Stages 3..5: delay line matching the multiplier
    logic [DLY-1:0] vd_reg;
    op_t            opd_reg [DLY];
    logic [63:0]    zrd_reg [DLY];
    logic [63:0]    zid_reg [DLY];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= '0;
        end else if (en) begin
            vd_reg <= {vd_reg[DLY-2:0], v2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            opd_reg[0] <= op2_reg;
            zrd_reg[0] <= zr2_reg;
            zid_reg[0] <= zi2_reg;
            for (int i = 1; i < DLY; i++) begin
                opd_reg[i] <= opd_reg[i-1];
                zrd_reg[i] <= zrd_reg[i-1];
                zid_reg[i] <= zid_reg[i-1];
            end
        end
    end

    // Stage 6: combine products, select result, output register
    logic [63:0] zr_next, zi_next;
    logic        out_valid_reg;
    logic [63:0] zr_reg, zi_reg;

    always_comb begin
        if (opd_reg[DLY-1] == OP_MUL) begin
            zr_next = sub_mod(m_rr, m_ii);
            zi_next = add_mod(m_ri, m_ir);
        end else begin
            zr_next = zrd_reg[DLY-1];
            zi_next = zid_reg[DLY-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vd_reg[DLY-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {zi_reg, zr_reg};

endmodule

>>> bench/gauss_alu_checker.sv
// Checker for the Gaussian integer ALU: predicts each result mod p and compares it on transfer.
`timescale 1ns / 1ps

module gauss_alu_checker
    import gimgalu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [255:0] s_tdata,    // a_re[63:0], a_im[127:64], b_re[191:128], b_im[255:192]
    input  logic [1:0]   s_tuser,    // op[1:0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,    // z_re[63:0], z_im[127:64]
    output int           n_errors,
    output int           n_pending
);

    // Modulus widened so that sums of two 128-bit products never overflow
    localparam logic [129:0] MOD_W = {66'd0, GOLD_P};

    typedef struct packed {
        logic [63:0] re;
        logic [63:0] im;
    } gauss_t;

    gauss_t z_queue[$];
    int     mismatches = 0;
    int     outstanding = 0;

    assign n_errors  = mismatches;
    assign n_pending = outstanding;

    function automatic logic [129:0] reduce_p(input logic [129:0] v);
        return v % MOD_W;
    endfunction

    // Exact arithmetic mod p; operands at or above p are folded back first
    function automatic gauss_t gauss_op_mod_p(input op_t op, input logic [63:0] ar,
                                              input logic [63:0] ai, input logic [63:0] br,
                                              input logic [63:0] bi);
        logic [129:0] xr, xi, yr, yi, zr, zi;
        gauss_t z;
        xr = reduce_p({66'd0, ar});
        xi = reduce_p({66'd0, ai});
        yr = reduce_p({66'd0, br});
        yi = reduce_p({66'd0, bi});
        case (op)
            OP_ADD: begin
                zr = reduce_p(xr + yr);
                zi = reduce_p(xi + yi);
            end
            OP_SUB: begin
                zr = reduce_p(xr + MOD_W - yr);
                zi = reduce_p(xi + MOD_W - yi);
            end
            OP_MUL: begin
                // (xr + i xi)(yr + i yi), with i*i = -1
                zr = reduce_p(reduce_p(xr * yr) + MOD_W - reduce_p(xi * yi));
                zi = reduce_p(xr * yi + xi * yr);
            end
            default: begin
                // conjugate of a; b plays no part, and a zero imaginary part stays zero
                zr = xr;
                zi = reduce_p(MOD_W - xi);
            end
        endcase
        z.re = zr[63:0];
        z.im = zi[63:0];
        return z;
    endfunction

    // One line per mismatch
    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("checker: %s mismatch at %0t ns: got %h, want %h", what, $time, got, want);
        mismatches++;
    endtask

    // Retire result transfers first, then queue the prediction for a new input transfer
    always @(posedge aclk) begin
        gauss_t want;
        if (!aresetn) begin
            z_queue.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (z_queue.size() == 0) begin
                    flag_mismatch("unexpected result", m_tdata[63:0], 64'd0);
                end else begin
                    want = z_queue.pop_front();
                    if (m_tdata[63:0] !== want.re)
                        flag_mismatch("z_re", m_tdata[63:0], want.re);
                    if (m_tdata[127:64] !== want.im)
                        flag_mismatch("z_im", m_tdata[127:64], want.im);
                end
            end
            if (s_tvalid && s_tready)
                z_queue.push_back(gauss_op_mod_p(op_t'(s_tuser), s_tdata[63:0],
                                                 s_tdata[127:64], s_tdata[191:128],
                                                 s_tdata[255:192]));
        end
        outstanding = z_queue.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the Gaussian integer ALU bench: clock, reset, operand stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module testbench;
    import gimgalu_pkg::*;

    localparam logic [63:0] PM1      = GOLD_P - 64'd1;
    localparam int          N_RANDOM = 1530;
    localparam int          N_PHASES = 6;
    localparam int          LIMIT    = 400000;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata  = '0;   // a_re[63:0], a_im[127:64], b_re[191:128], b_im[255:192]
    logic [1:0]   s_axis_tuser  = OP_ADD; // op[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;         // z_re[63:0], z_im[127:64]

    int n_errors;
    int n_pending;
    int cycles    = 0;
    int hold_left = 0;
    int roll_rx;
    bit calm_send = 1'b0;
    bit calm_recv = 1'b0;

    gaussian_int_mod_goldilocks_alu u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gauss_alu_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    always #10 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Result side back-pressure: mostly ready, short stalls, now and then a long one
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (calm_recv) begin
            m_axis_tready <= 1'b1;
        end else begin
            roll_rx = $urandom_range(0, 99);
            if (roll_rx < 75) begin
                m_axis_tready <= 1'b1;
            end else if (roll_rx < 95) begin
                m_axis_tready <= 1'b0;
                hold_left = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                hold_left = $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (calm_send)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // One operand part: mostly uniform below p, some corners, a few at or above p
    function automatic logic [63:0] pick_part();
        int roll;
        logic [63:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return GOLD_P + {32'd0, $urandom_range(0, 32'hFFFF_FFFE)};
        if (roll < 15) begin
            case ($urandom_range(0, 6))
                0:       return 64'd0;
                1:       return 64'd1;
                2:       return PM1;
                3:       return GOLD_P - 64'd2;
                4:       return 64'h0000_0000_FFFF_FFFF;
                5:       return 64'h0000_0001_0000_0000;
                default: return 64'h8000_0000_0000_0000;
            endcase
        end
        v = {$urandom, $urandom};
        while (v >= GOLD_P)
            v = {$urandom, $urandom};
        return v;
    endfunction

    // Present one item after a random gap and hold it until the transfer
    task automatic push_op(input op_t op, input logic [63:0] ar, input logic [63:0] ai,
                           input logic [63:0] br, input logic [63:0] bi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom};
            s_axis_tuser  <= 2'($urandom_range(0, 3));
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bi, br, ai, ar};
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int per_phase;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: field extremes and wrap points for every op
        push_op(OP_ADD,  64'd0, 64'd0, 64'd0, 64'd0);
        push_op(OP_ADD,  PM1, PM1, PM1, PM1);
        push_op(OP_ADD,  PM1, 64'd1, 64'd1, PM1);
        push_op(OP_SUB,  64'd0, 64'd1, 64'd1, 64'd0);
        push_op(OP_SUB,  PM1, 64'd0, PM1, PM1);
        push_op(OP_SUB,  64'd0, 64'h8000_0000_0000_0000, PM1, 64'h0000_0000_FFFF_FFFF);
        push_op(OP_MUL,  PM1, PM1, PM1, PM1);
        push_op(OP_MUL,  64'd0, 64'd1, 64'd0, 64'd1);           // i * i
        push_op(OP_MUL,  64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF,
                         64'h0000_0001_0000_0000, 64'h8000_0000_0000_0000);
        push_op(OP_MUL,  64'd0, 64'd0, PM1, PM1);
        push_op(OP_MUL,  GOLD_P - 64'd2, 64'd1, PM1, GOLD_P - 64'd2);
        push_op(OP_CONJ, 64'd5, 64'd0, PM1, PM1);               // zero imaginary part
        push_op(OP_CONJ, PM1, PM1, 64'd0, 64'd0);
        push_op(OP_CONJ, 64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        // Non-canonical operands, folded once by p
        push_op(OP_ADD,  GOLD_P, 64'hFFFF_FFFF_FFFF_FFFF, GOLD_P + 64'd5, GOLD_P);
        push_op(OP_SUB,  64'hFFFF_FFFF_FFFF_FFFF, GOLD_P, GOLD_P, 64'hFFFF_FFFF_FFFF_FFFF);
        push_op(OP_MUL,  64'hFFFF_FFFF_FFFF_FFFF, GOLD_P + 64'd1,
                         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
        push_op(OP_CONJ, GOLD_P + 64'd7, GOLD_P, 64'd0, 64'd0);
        push_op(OP_CONJ, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3, 64'd4);

        // Random: most phases send with random idling, phases 2 and 5 send back-to-back traffic
        per_phase = N_RANDOM / N_PHASES;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            calm_send = (ph == 2) || (ph == 5);
            calm_recv = (ph == 2) || (ph == 4);
            for (int k = 0; k < per_phase; k++)
                push_op(op_t'($urandom_range(0, 3)), pick_part(), pick_part(),
                        pick_part(), pick_part());
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow the pipeline depth for any stray output
        while (n_pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (n_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
